### rtl/four_sum_two_pointer_unit_defines.svh
// Assertion macros for the four-sum search unit.
// Expects signals named clock and reset in the module that uses them.
`ifndef FOUR_SUM_TWO_POINTER_UNIT_DEFINES_SVH
`define FOUR_SUM_TWO_POINTER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FSP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FSP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/fsp_pkg.sv
// Shared types and constants for the four-sum search unit.
// No dependencies; used by fsp_sum_unit and four_sum_two_pointer_unit.
package fsp_pkg;

   localparam int VAL_W = 32;
   localparam int ACC_W = 34;

   localparam logic [1:0] MODE_CLEAR = 2'd0;
   localparam logic [1:0] MODE_LOAD  = 2'd1;
   localparam logic [1:0] MODE_FETCH = 2'd2;

   typedef struct packed {
      logic [1:0]              mode;
      logic signed [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic                    found;
      logic signed [VAL_W-1:0] first_value;
      logic signed [VAL_W-1:0] second_value;
      logic signed [VAL_W-1:0] third_value;
      logic signed [VAL_W-1:0] fourth_value;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic add;
   } sum_ctl_type;

   typedef struct packed {
      logic gt;
      logic eq;
   } sum_sts_type;

endpackage

### rtl/fsp_ram.sv
// Generic single-write, single-read memory with registered read data.
// No dependencies.
module fsp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/fsp_sum_unit.sv
// Shared 34-bit accumulator with signed compare against a reference value.
// Depends on fsp_pkg.
module fsp_sum_unit (
   input  logic                              clock,
   input  fsp_pkg::sum_ctl_type              ctl,
   input  logic signed [fsp_pkg::VAL_W-1:0]  operand,
   input  logic signed [fsp_pkg::VAL_W-1:0]  ref_val,
   output logic signed [fsp_pkg::VAL_W-1:0]  acc_low,
   output fsp_pkg::sum_sts_type              sts
);

   logic signed [fsp_pkg::ACC_W-1:0] acc_ff;
   logic signed [fsp_pkg::ACC_W-1:0] acc_in;
   logic signed [fsp_pkg::ACC_W-1:0] op_ext;
   logic signed [fsp_pkg::ACC_W-1:0] ref_ext;

   assign op_ext  = {{(fsp_pkg::ACC_W - fsp_pkg::VAL_W){operand[fsp_pkg::VAL_W-1]}}, operand};
   assign ref_ext = {{(fsp_pkg::ACC_W - fsp_pkg::VAL_W){ref_val[fsp_pkg::VAL_W-1]}}, ref_val};

   always_comb begin
      acc_in = acc_ff;
      if (ctl.load) begin
         acc_in = op_ext;
      end else if (ctl.add) begin
         acc_in = acc_ff + op_ext;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc_low = acc_ff[fsp_pkg::VAL_W-1:0];
   assign sts.gt  = (acc_ff > ref_ext);
   assign sts.eq  = (acc_ff == ref_ext);

endmodule

### rtl/four_sum_two_pointer_unit.sv
// Top level of the four-sum search unit: sequencer, store and pointers.
// Depends on fsp_pkg, fsp_ram, fsp_sum_unit and the assertion macro header.
//
// Usage:
//   Items enter on req_data when start is high and busy is low. Mode clear
//   empties the store in the accept cycle. Mode load inserts value into the
//   store, kept in ascending order: each larger element moves up one slot
//   until the value lands in slot 0 or stops above one that is not larger;
//   busy is high meanwhile. A load into a full store is dropped.
//   Mode fetch resumes the search for four values that add up to the target
//   and answers with one rsp_valid strobe on rsp_data. Each probe reads the
//   store four times through its single read port and sums in one shared
//   accumulator; a fetch may probe a number of quadruples that grows with
//   the cube of the number of stored values. A fetch with fewer than four
//   values answers not found in the cycle after start; one after the search
//   is exhausted also answers not found. Clear and the unused mode leave busy
//   low. csr_wr_en writes target_sum; write it only while idle.
//   Reset empties the store, clears target_sum and rewinds the search.
//   Results are shown for one cycle only; the receiver cannot stall.
`include "four_sum_two_pointer_unit_defines.svh"
module four_sum_two_pointer_unit #(
   parameter int MAX_ELEMENTS = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  fsp_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   output fsp_pkg::rsp_type                  rsp_data,
   input  logic                              csr_wr_en,
   input  logic signed [fsp_pkg::VAL_W-1:0]  csr_wr_data
);

   localparam int IDX_W = $clog2(MAX_ELEMENTS);
   localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
   localparam int PW    = CNT_W + 1;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ELEMENTS);

   typedef enum logic [7:0] {
      ST_IDLE    = 8'b0000_0001,
      ST_INS_RD  = 8'b0000_0010,
      ST_INS_WT  = 8'b0000_0100,
      ST_INS_CMP = 8'b0000_1000,
      ST_SRCH    = 8'b0001_0000,
      ST_SUM_RD  = 8'b0010_0000,
      ST_SUM_DRN = 8'b0100_0000,
      ST_SUM_CHK = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] oi_ff, oi_in;
   logic [CNT_W-1:0] sj_ff, sj_in;
   logic [CNT_W-1:0] lo_ff, lo_in;
   logic [CNT_W-1:0] hi_ff, hi_in;
   logic [CNT_W-1:0] pos_ff, pos_in;
   logic             started_ff, started_in;
   logic [1:0]       k_ff, k_in;
   logic             rd_vld_ff, rd_vld_in;
   logic [1:0]       tag_ff, tag_in;
   logic             rsp_valid_ff, rsp_valid_in;
   fsp_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic signed [fsp_pkg::VAL_W-1:0] target_ff;
   logic signed [fsp_pkg::VAL_W-1:0] value_ff, value_in;
   logic signed [fsp_pkg::VAL_W-1:0] q_ff [4];

   logic                      ram_wr_en;
   logic [IDX_W-1:0]          ram_wr_addr;
   logic [fsp_pkg::VAL_W-1:0] ram_wr_data;
   logic [IDX_W-1:0]          ram_rd_addr;
   logic [fsp_pkg::VAL_W-1:0] ram_rd_data;

   fsp_pkg::sum_ctl_type             sum_ctl;
   fsp_pkg::sum_sts_type             sum_sts;
   logic signed [fsp_pkg::VAL_W-1:0] sum_ref;
   logic signed [fsp_pkg::VAL_W-1:0] acc_low;

   logic [CNT_W-1:0] pos_dec;
   logic [CNT_W-1:0] probe_ptr;
   logic             outer_ok;
   logic             second_ok;
   logic             pair_ok;

   fsp_ram #(
      .WIDTH (fsp_pkg::VAL_W),
      .DEPTH (MAX_ELEMENTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   fsp_sum_unit u_sum (
      .clock   (clock),
      .ctl     (sum_ctl),
      .operand (ram_rd_data),
      .ref_val (sum_ref),
      .acc_low (acc_low),
      .sts     (sum_sts)
   );

   assign pos_dec   = pos_ff - 1'b1;
   assign outer_ok  = (({1'b0, oi_ff} + PW'(3)) < {1'b0, cnt_ff});
   assign second_ok = (({1'b0, sj_ff} + PW'(2)) < {1'b0, cnt_ff});
   assign pair_ok   = (lo_ff < hi_ff) && (hi_ff < cnt_ff);

   always_comb begin
      case (k_ff)
         2'd0:    probe_ptr = oi_ff;
         2'd1:    probe_ptr = sj_ff;
         2'd2:    probe_ptr = lo_ff;
         default: probe_ptr = hi_ff;
      endcase
   end

   // Insertion compares the moved element with the new value; search
   // compares the four-value sum with the target.
   assign sum_ref      = (state_ff == ST_INS_CMP) ? value_ff : target_ff;
   assign sum_ctl.load = (state_ff == ST_INS_WT) || (rd_vld_ff && (tag_ff == 2'd0));
   assign sum_ctl.add  = rd_vld_ff && (tag_ff != 2'd0);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      oi_in        = oi_ff;
      sj_in        = sj_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      pos_in       = pos_ff;
      started_in   = started_ff;
      k_in         = k_ff;
      rd_vld_in    = 1'b0;
      tag_in       = tag_ff;
      value_in     = value_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = pos_ff[IDX_W-1:0];
      ram_wr_data  = value_ff;
      ram_rd_addr  = pos_dec[IDX_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (req_data.mode)
                  fsp_pkg::MODE_CLEAR: begin
                     cnt_in     = '0;
                     started_in = 1'b0;
                  end
                  fsp_pkg::MODE_LOAD: begin
                     started_in = 1'b0;
                     if (cnt_ff != CNT_MAX) begin
                        pos_in   = cnt_ff;
                        value_in = req_data.value;
                        state_in = ST_INS_RD;
                     end
                  end
                  fsp_pkg::MODE_FETCH: begin
                     if (cnt_ff < CNT_W'(4)) begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = '0;
                     end else begin
                        if (!started_ff) begin
                           oi_in      = '0;
                           sj_in      = CNT_W'(1);
                           lo_in      = CNT_W'(2);
                           hi_in      = cnt_ff - 1'b1;
                           started_in = 1'b1;
                        end
                        state_in = ST_SRCH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_INS_RD: begin
            if (pos_ff == '0) begin
               ram_wr_en = 1'b1;
               cnt_in    = cnt_ff + 1'b1;
               state_in  = ST_IDLE;
            end else begin
               state_in = ST_INS_WT;
            end
         end

         ST_INS_WT: begin
            state_in = ST_INS_CMP;
         end

         ST_INS_CMP: begin
            ram_wr_en = 1'b1;
            if (sum_sts.gt) begin
               // shift the larger element up one slot and keep walking
               ram_wr_data = acc_low;
               pos_in      = pos_dec;
               state_in    = ST_INS_RD;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = ST_IDLE;
            end
         end

         ST_SRCH: begin
            if (!outer_ok) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               state_in     = ST_IDLE;
            end else if (!second_ok) begin
               oi_in = oi_ff + 1'b1;
               sj_in = oi_ff + CNT_W'(2);
               lo_in = oi_ff + CNT_W'(3);
               hi_in = cnt_ff - 1'b1;
            end else if (!pair_ok) begin
               sj_in = sj_ff + 1'b1;
               lo_in = sj_ff + CNT_W'(2);
               hi_in = cnt_ff - 1'b1;
            end else begin
               k_in     = 2'd0;
               state_in = ST_SUM_RD;
            end
         end

         ST_SUM_RD: begin
            ram_rd_addr = probe_ptr[IDX_W-1:0];
            rd_vld_in   = 1'b1;
            tag_in      = k_ff;
            k_in        = k_ff + 1'b1;
            if (k_ff == 2'd3) begin
               state_in = ST_SUM_DRN;
            end
         end

         ST_SUM_DRN: begin
            state_in = ST_SUM_CHK;
         end

         ST_SUM_CHK: begin
            if (sum_sts.eq) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.found        = 1'b1;
               rsp_data_in.first_value  = q_ff[0];
               rsp_data_in.second_value = q_ff[1];
               rsp_data_in.third_value  = q_ff[2];
               rsp_data_in.fourth_value = q_ff[3];
               lo_in                    = lo_ff + 1'b1;
               hi_in                    = hi_ff - 1'b1;
               state_in                 = ST_IDLE;
            end else begin
               if (sum_sts.gt) begin
                  hi_in = hi_ff - 1'b1;
               end else begin
                  lo_in = lo_ff + 1'b1;
               end
               state_in = ST_SRCH;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         oi_ff        <= '0;
         sj_ff        <= CNT_W'(1);
         lo_ff        <= CNT_W'(2);
         hi_ff        <= '0;
         pos_ff       <= '0;
         started_ff   <= 1'b0;
         k_ff         <= '0;
         rd_vld_ff    <= 1'b0;
         tag_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         target_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         oi_ff        <= oi_in;
         sj_ff        <= sj_in;
         lo_ff        <= lo_in;
         hi_ff        <= hi_in;
         pos_ff       <= pos_in;
         started_ff   <= started_in;
         k_ff         <= k_in;
         rd_vld_ff    <= rd_vld_in;
         tag_ff       <= tag_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            target_ff <= csr_wr_data;
         end
      end
   end

   // hold each fetched value of the probed quadruple for the result
   always_ff @(posedge clock) begin
      value_ff    <= value_in;
      rsp_data_ff <= rsp_data_in;
      if (rd_vld_ff) begin
         q_ff[tag_ff] <= ram_rd_data;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `FSP_ASSERT_NEXT(a_no_rsp_after_non_fetch, start && !busy && (req_data.mode != fsp_pkg::MODE_FETCH), !rsp_valid, "result after an item that is not a fetch")
   `FSP_ASSERT_NOW(a_rsp_when_idle, rsp_valid, !busy, "result shown while sequencer busy")
   `FSP_ASSERT_NOW(a_probe_order, state_ff == ST_SUM_RD, (oi_ff < sj_ff) && (sj_ff < lo_ff) && (lo_ff < hi_ff), "probe pointers out of order")

endmodule
